[rtl/lslf_pkg.sv]
// ----------------------------------------------------------------------------
// Least-squares line fit package
// Shared sizes, the cluster summary type and the state codes of the fit unit.
// ----------------------------------------------------------------------------
package lslf_pkg;

  // Block configuration.
  localparam int MAX_POINTS  = 4096;
  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_W       = 48;
  localparam int QUEUE_DEPTH = 2;

  // Derived widths.
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = COORD_BITS + CNT_W;
  localparam int ACC_W  = 2 * COORD_BITS + CNT_W;
  localparam int V_W    = 2 * COORD_BITS + 2 * CNT_W + 1;
  localparam int P_W    = 2 * V_W;
  localparam int DVD_W  = P_W + FRAC_BITS;
  localparam int MCNT_W = $clog2(V_W + 1);
  localparam int DCNT_W = $clog2(DVD_W + 1);
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Minus one in the output fixed-point format.
  localparam logic [OUT_W-1:0] NEG_ONE = ~(OUT_W'(1) << FRAC_BITS) + OUT_W'(1);

  // Saturation limits of the output.
  localparam logic [DVD_W-1:0] SAT_NEG_MAG = DVD_W'(1) << (OUT_W - 1);
  localparam logic [DVD_W-1:0] SAT_POS_MAG = (DVD_W'(1) << (OUT_W - 1)) - DVD_W'(1);
  localparam logic [OUT_W-1:0] SAT_NEG     = OUT_W'(1) << (OUT_W - 1);
  localparam logic [OUT_W-1:0] SAT_POS     = (OUT_W'(1) << (OUT_W - 1)) - OUT_W'(1);

  // Summary of one finished cluster, handed from front to back.
  typedef struct packed {
    logic [CNT_W-1:0]        n;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [ACC_W-1:0] sxx;
    logic signed [ACC_W-1:0] syy;
    logic signed [ACC_W-1:0] sxy;
    logic                    dropped;
  } snap_t;

  // Product steps of the solve sequence.
  typedef enum logic [3:0] {
    ST_N_SXX,
    ST_SX_SX,
    ST_N_SYY,
    ST_SY_SY,
    ST_N_SXY,
    ST_SX_SY,
    ST_VX_VY,
    ST_CV_CV,
    ST_CN_HI,
    ST_CN_LO
  } step_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MSTART,
    BK_MWAIT,
    BK_DECIDE,
    BK_DSTART,
    BK_DWAIT,
    BK_OUT
  } bk_state_t;

  typedef enum logic [1:0] {
    MU_IDLE,
    MU_RUN,
    MU_NEG,
    MU_DONE
  } mu_state_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_RUN,
    DV_ROUND,
    DV_SAT,
    DV_DONE
  } dv_state_t;

endpackage

[rtl/lslf_front.sv]
// ----------------------------------------------------------------------------
// Least-squares line fit front end
// Accumulates point count and moment sums, and hands a cluster summary on.
// ----------------------------------------------------------------------------
module lslf_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [lslf_pkg::COORD_BITS-1:0] x_coord,
  input  logic signed [lslf_pkg::COORD_BITS-1:0] y_coord,
  input  logic                                 last_point,
  output logic                                 push,
  output lslf_pkg::snap_t                      push_data,
  input  logic                                 q_full
);
  import lslf_pkg::*;

  logic [CNT_W-1:0]        point_count;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic signed [ACC_W-1:0] sum_xx, sum_yy, sum_xy;
  logic                    dropped_flag;
  logic                    accept, room;
  logic signed [2*COORD_BITS-1:0] pxx, pyy, pxy;
  snap_t                   acc_next;

  // A request is taken whenever the queue has a free slot.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign room     = point_count < CNT_W'(MAX_POINTS);

  // Point products.
  assign pxx = x_coord * x_coord;
  assign pyy = y_coord * y_coord;
  assign pxy = x_coord * y_coord;

  // Sums after this point.
  always_comb begin
    acc_next.n       = point_count;
    acc_next.sx      = sum_x;
    acc_next.sy      = sum_y;
    acc_next.sxx     = sum_xx;
    acc_next.syy     = sum_yy;
    acc_next.sxy     = sum_xy;
    acc_next.dropped = dropped_flag;
    if (room) begin
      acc_next.n   = point_count + CNT_W'(1);
      acc_next.sx  = sum_x + SUM_W'(x_coord);
      acc_next.sy  = sum_y + SUM_W'(y_coord);
      acc_next.sxx = sum_xx + ACC_W'(pxx);
      acc_next.syy = sum_yy + ACC_W'(pyy);
      acc_next.sxy = sum_xy + ACC_W'(pxy);
    end else begin
      acc_next.dropped = 1'b1;
    end
  end

  assign push      = accept && last_point;
  assign push_data = acc_next;

  // Accumulator registers, cleared once a cluster is handed on.
  always_ff @(posedge clk) begin
    if (rst || push) begin
      point_count  <= '0;
      sum_x        <= '0;
      sum_y        <= '0;
      sum_xx       <= '0;
      sum_yy       <= '0;
      sum_xy       <= '0;
      dropped_flag <= 1'b0;
    end else if (accept) begin
      point_count  <= acc_next.n;
      sum_x        <= acc_next.sx;
      sum_y        <= acc_next.sy;
      sum_xx       <= acc_next.sxx;
      sum_yy       <= acc_next.syy;
      sum_xy       <= acc_next.sxy;
      dropped_flag <= acc_next.dropped;
    end
  end

endmodule

[rtl/lslf_queue.sv]
// ----------------------------------------------------------------------------
// Least-squares line fit summary queue
// Short first-in first-out store of cluster summaries between front and back.
// ----------------------------------------------------------------------------
module lslf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lslf_pkg::snap_t din,
  input  logic            pop,
  output lslf_pkg::snap_t dout,
  output logic            full,
  output logic            empty
);
  import lslf_pkg::*;

  snap_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = count == QCNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign dout  = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

endmodule

[rtl/lslf_mul.sv]
// ----------------------------------------------------------------------------
// Least-squares line fit serial multiplier
// Signed shift-and-add multiplier, one operand bit per cycle.
// ----------------------------------------------------------------------------
module lslf_mul (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [lslf_pkg::V_W-1:0] op_a,
  input  logic signed [lslf_pkg::V_W-1:0] op_b,
  output logic                            done,
  output logic signed [lslf_pkg::P_W-1:0] product
);
  import lslf_pkg::*;

  mu_state_t         state, state_next;
  logic [P_W-1:0]    acc, a_sh;
  logic [V_W-1:0]    b_sh, mag_a, mag_b;
  logic [MCNT_W-1:0] cnt;
  logic              neg;

  assign mag_a = op_a[V_W-1] ? V_W'(-op_a) : op_a;
  assign mag_b = op_b[V_W-1] ? V_W'(-op_b) : op_b;

  always_ff @(posedge clk) begin
    if (rst) state <= MU_IDLE;
    else     state <= state_next;
  end

  // Sequencing.
  always_comb begin
    state_next = state;
    done       = 1'b0;
    unique case (state)
      MU_IDLE: if (start) state_next = MU_RUN;
      MU_RUN:  if (cnt == MCNT_W'(V_W - 1)) state_next = MU_NEG;
      MU_NEG:  state_next = MU_DONE;
      MU_DONE: begin
        done       = 1'b1;
        state_next = MU_IDLE;
      end
      default: state_next = MU_IDLE;
    endcase
  end

  // Datapath: add the shifted multiplicand for each set multiplier bit.
  always_ff @(posedge clk) begin
    case (state)
      MU_IDLE: begin
        acc  <= '0;
        a_sh <= {{(P_W - V_W){1'b0}}, mag_a};
        b_sh <= mag_b;
        neg  <= op_a[V_W-1] ^ op_b[V_W-1];
        cnt  <= '0;
      end
      MU_RUN: begin
        if (b_sh[0]) acc <= acc + a_sh;
        a_sh <= a_sh << 1;
        b_sh <= b_sh >> 1;
        cnt  <= cnt + MCNT_W'(1);
      end
      MU_NEG: product <= neg ? -acc : acc;
      default: ;
    endcase
  end

endmodule

[rtl/lslf_div.sv]
// ----------------------------------------------------------------------------
// Least-squares line fit serial divider
// Scaled restoring division with round-to-nearest and output saturation.
// ----------------------------------------------------------------------------
module lslf_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [lslf_pkg::P_W-1:0]   num,
  input  logic [lslf_pkg::V_W-1:0]          den,
  output logic                              done,
  output logic [lslf_pkg::OUT_W-1:0]        quot
);
  import lslf_pkg::*;

  dv_state_t         state, state_next;
  logic [DVD_W-1:0]  dvd;
  logic [V_W-1:0]    rem, dreg;
  logic [V_W:0]      rem_sh;
  logic              qbit, neg;
  logic [DCNT_W-1:0] cnt;
  logic [P_W-1:0]    mag;

  assign mag    = num[P_W-1] ? P_W'(-num) : num;
  assign rem_sh = {rem, dvd[DVD_W-1]};
  assign qbit   = rem_sh >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) state <= DV_IDLE;
    else     state <= state_next;
  end

  // Sequencing.
  always_comb begin
    state_next = state;
    done       = 1'b0;
    unique case (state)
      DV_IDLE:  if (start) state_next = DV_RUN;
      DV_RUN:   if (cnt == DCNT_W'(DVD_W - 1)) state_next = DV_ROUND;
      DV_ROUND: state_next = DV_SAT;
      DV_SAT:   state_next = DV_DONE;
      DV_DONE: begin
        done       = 1'b1;
        state_next = DV_IDLE;
      end
      default: state_next = DV_IDLE;
    endcase
  end

  // Datapath: quotient bits shift in where dividend bits shift out.
  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        dvd  <= {mag, {FRAC_BITS{1'b0}}};
        dreg <= den;
        rem  <= '0;
        neg  <= num[P_W-1];
        cnt  <= '0;
      end
      DV_RUN: begin
        rem <= qbit ? V_W'(rem_sh - {1'b0, dreg}) : V_W'(rem_sh);
        dvd <= {dvd[DVD_W-2:0], qbit};
        cnt <= cnt + DCNT_W'(1);
      end
      DV_ROUND: begin
        if (rem >= dreg - rem) dvd <= dvd + DVD_W'(1);
      end
      DV_SAT: begin
        if (neg) quot <= (dvd > SAT_NEG_MAG) ? SAT_NEG : OUT_W'(-dvd);
        else     quot <= (dvd > SAT_POS_MAG) ? SAT_POS : dvd[OUT_W-1:0];
      end
      default: ;
    endcase
  end

endmodule

[rtl/lslf_back.sv]
// ----------------------------------------------------------------------------
// Least-squares line fit back end
// Solves the normal equations of one cluster and holds the result request.
// ----------------------------------------------------------------------------
module lslf_back (
  input  logic                              clk,
  input  logic                              rst,
  input  lslf_pkg::snap_t                   snap,
  input  logic                              q_empty,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lslf_pkg::OUT_W-1:0] coef_a,
  output logic signed [lslf_pkg::OUT_W-1:0] coef_b,
  output logic signed [lslf_pkg::OUT_W-1:0] coef_c,
  output logic                              degenerate,
  output logic                              overflowed
);
  import lslf_pkg::*;

  bk_state_t               state, state_next;
  step_t                   step;
  logic signed [P_W-1:0]   t, cn, product, diff;
  logic signed [V_W-1:0]   vx, vy, cv, op_a, op_b, div_den;
  logic signed [P_W-1:0]   div_num;
  logic [OUT_W-1:0]        quot, slope, cterm;
  logic                    first, degen, div_phase;
  logic                    mul_start, mul_done, div_start, div_done;
  logic                    vx_le0, vy_le0, load_out;

  assign diff   = t - product;
  assign vx_le0 = vx[V_W-1] || (vx == '0);
  assign vy_le0 = vy[V_W-1] || (vy == '0);

  // Multiplier operands for each step.
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step)
      ST_N_SXX: begin
        op_a = {{(V_W - CNT_W){1'b0}}, snap.n};
        op_b = {{(V_W - ACC_W){snap.sxx[ACC_W-1]}}, snap.sxx};
      end
      ST_SX_SX: begin
        op_a = {{(V_W - SUM_W){snap.sx[SUM_W-1]}}, snap.sx};
        op_b = {{(V_W - SUM_W){snap.sx[SUM_W-1]}}, snap.sx};
      end
      ST_N_SYY: begin
        op_a = {{(V_W - CNT_W){1'b0}}, snap.n};
        op_b = {{(V_W - ACC_W){snap.syy[ACC_W-1]}}, snap.syy};
      end
      ST_SY_SY: begin
        op_a = {{(V_W - SUM_W){snap.sy[SUM_W-1]}}, snap.sy};
        op_b = {{(V_W - SUM_W){snap.sy[SUM_W-1]}}, snap.sy};
      end
      ST_N_SXY: begin
        op_a = {{(V_W - CNT_W){1'b0}}, snap.n};
        op_b = {{(V_W - ACC_W){snap.sxy[ACC_W-1]}}, snap.sxy};
      end
      ST_SX_SY: begin
        op_a = {{(V_W - SUM_W){snap.sx[SUM_W-1]}}, snap.sx};
        op_b = {{(V_W - SUM_W){snap.sy[SUM_W-1]}}, snap.sy};
      end
      ST_VX_VY: begin
        op_a = vx;
        op_b = vy;
      end
      ST_CV_CV: begin
        op_a = cv;
        op_b = cv;
      end
      ST_CN_HI: begin
        if (first) begin
          op_a = {{(V_W - ACC_W){snap.sxx[ACC_W-1]}}, snap.sxx};
          op_b = {{(V_W - SUM_W){snap.sy[SUM_W-1]}}, snap.sy};
        end else begin
          op_a = {{(V_W - ACC_W){snap.syy[ACC_W-1]}}, snap.syy};
          op_b = {{(V_W - SUM_W){snap.sx[SUM_W-1]}}, snap.sx};
        end
      end
      ST_CN_LO: begin
        if (first) begin
          op_a = {{(V_W - SUM_W){snap.sx[SUM_W-1]}}, snap.sx};
          op_b = {{(V_W - ACC_W){snap.sxy[ACC_W-1]}}, snap.sxy};
        end else begin
          op_a = {{(V_W - SUM_W){snap.sy[SUM_W-1]}}, snap.sy};
          op_b = {{(V_W - ACC_W){snap.sxy[ACC_W-1]}}, snap.sxy};
        end
      end
      default: ;
    endcase
  end

  // The divider takes the slope numerator first, then the intercept numerator.
  assign div_den = first ? vx : vy;
  assign div_num = div_phase ? cn : {{(P_W - V_W){cv[V_W-1]}}, cv};

  lslf_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .op_a    (op_a),
    .op_b    (op_b),
    .done    (mul_done),
    .product (product)
  );

  lslf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  // Solve sequencer.
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      BK_IDLE: if (!q_empty) state_next = BK_MSTART;
      BK_MSTART: begin
        mul_start  = 1'b1;
        state_next = BK_MWAIT;
      end
      BK_MWAIT: begin
        if (mul_done) begin
          case (step) inside
            ST_SX_SY: state_next = BK_DECIDE;
            ST_CN_LO: state_next = BK_DSTART;
            default:  state_next = BK_MSTART;
          endcase
        end
      end
      BK_DECIDE: begin
        if (vx_le0 && vy_le0) state_next = BK_OUT;
        else                  state_next = BK_MSTART;
      end
      BK_DSTART: begin
        div_start  = 1'b1;
        state_next = BK_DWAIT;
      end
      BK_DWAIT: begin
        if (div_done) state_next = div_phase ? BK_OUT : BK_DSTART;
      end
      BK_OUT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign pop = load_out;

  // Intermediate results of the solve.
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        step      <= ST_N_SXX;
        degen     <= 1'b0;
        div_phase <= 1'b0;
      end
      BK_MWAIT: begin
        if (mul_done) begin
          case (step)
            ST_SX_SX: begin
              vx   <= diff[V_W-1:0];
              step <= ST_N_SYY;
            end
            ST_SY_SY: begin
              vy   <= diff[V_W-1:0];
              step <= ST_N_SXY;
            end
            ST_SX_SY: cv <= diff[V_W-1:0];
            ST_CV_CV: begin
              first <= (t > product) && (vx > vy);
              step  <= ST_CN_HI;
            end
            ST_CN_LO: cn <= diff;
            default: begin
              t    <= product;
              step <= step_t'(step + 4'd1);
            end
          endcase
        end
      end
      BK_DECIDE: begin
        if (vx_le0 && vy_le0) begin
          degen <= 1'b1;
        end else if (vx_le0) begin
          first <= 1'b0;
          step  <= ST_CN_HI;
        end else if (vy_le0) begin
          first <= 1'b1;
          step  <= ST_CN_HI;
        end else begin
          step <= ST_VX_VY;
        end
      end
      BK_DWAIT: begin
        if (div_done) begin
          if (div_phase) cterm <= quot;
          else           slope <= quot;
          div_phase <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      degenerate <= degen;
      overflowed <= snap.dropped;
      if (degen) begin
        coef_a <= '0;
        coef_b <= '0;
        coef_c <= '0;
      end else begin
        coef_a <= first ? slope : NEG_ONE;
        coef_b <= first ? NEG_ONE : slope;
        coef_c <= cterm;
      end
    end
  end

endmodule

[rtl/least_squares_line_fit_unit.sv]
// ----------------------------------------------------------------------------
// Least-squares line fit unit
// Fits a straight line a*x + b*y + c = 0 to a cluster of 2D points.
// ----------------------------------------------------------------------------
// Points enter on the input channel (in_valid) at one per cycle while in_stall is low.
// The point flagged last_point closes the cluster: its sums go into a
// two-entry queue and the accumulators clear at once, so the next cluster
// may start in the following cycle. Up to 4096 points per cluster are used;
// later ones are dropped and reported through overflowed.
// The back end solves one cluster at a time with a serial 59x59 multiplier
// (up to ten products) and a serial divider (two quotients). The solve time
// of a cluster sets the cluster rate, while points flow at one per cycle
// until the queue holds two unsolved clusters, when in_stall rises.
// The result request is held in an output register until out_stall is low.
// While the receiver stalls the next cluster is still solved, and then waits.
// Reset clears the sums, the queue and the result valid flag.
// ----------------------------------------------------------------------------
module least_squares_line_fit_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [lslf_pkg::COORD_BITS-1:0] x_coord,
  input  logic signed [lslf_pkg::COORD_BITS-1:0] y_coord,
  input  logic                                   last_point,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [lslf_pkg::OUT_W-1:0]      coef_a,
  output logic signed [lslf_pkg::OUT_W-1:0]      coef_b,
  output logic signed [lslf_pkg::OUT_W-1:0]      coef_c,
  output logic                                   degenerate,
  output logic                                   overflowed
);
  import lslf_pkg::*;

  logic  push, pop, q_full, q_empty;
  snap_t push_data, head;

  lslf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .last_point (last_point),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  lslf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_data),
    .pop   (pop),
    .dout  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  lslf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .snap       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .coef_a     (coef_a),
    .coef_b     (coef_b),
    .coef_c     (coef_c),
    .degenerate (degenerate),
    .overflowed (overflowed)
  );

endmodule
